@@ design/timed_observation_window_store_assert.svh @@
// assertion macros for the timed observation window store
// used by the top level, expects clk and rst_n in scope
`ifndef TIMED_OBSERVATION_WINDOW_STORE_ASSERT_SVH
`define TIMED_OBSERVATION_WINDOW_STORE_ASSERT_SVH

// same-cycle implication
`define TOWT_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TOWT_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/towt_pkg.sv @@
// shared types and constants for the timed observation window store
// no dependencies
package towt_pkg;

    localparam int TIME_W = 32;
    localparam int EV_W   = 8;
    localparam int THR_W  = 24;

    localparam logic REQ_ADD  = 1'b0;
    localparam logic REQ_READ = 1'b1;

    localparam logic CFG_SLICE_LENGTH   = 1'b0;
    localparam logic CFG_HISTORY_SLICES = 1'b1;

    localparam logic [15:0] SLICE_LENGTH_RST   = 16'd100;
    localparam logic [7:0]  HISTORY_SLICES_RST = 8'd10;

    localparam logic [8:0] SLICE_SAT = 9'd256;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_DROP,
        S_INSERT,
        S_EVICT,
        S_RSEL,
        S_RDIV,
        S_DONE
    } state_t;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_SHIFT,
        OP_INSERT
    } cell_op_t;

    typedef struct packed {
        cell_op_t            op;
        logic [TIME_W-1:0]   new_time;
        logic [EV_W-1:0]     new_ev;
    } row_ctrl_t;

    typedef struct packed {
        logic                head_exp;
        logic [TIME_W-1:0]   rd_time;
        logic [EV_W-1:0]     rd_ev;
    } row_stat_t;

endpackage

@@ design/towt_cell.sv @@
// one list entry: timestamp and evidence, shifts to or from its neighbours
// depends on towt_pkg
module towt_cell
    import towt_pkg::*;
(
    input  logic              clk,
    input  row_ctrl_t         ctrl,
    input  logic [TIME_W-1:0] newest,
    input  logic [THR_W-1:0]  thr,
    input  logic              cell_valid,
    input  logic              le_left,
    input  logic [TIME_W-1:0] left_ts,
    input  logic [EV_W-1:0]   left_ev,
    input  logic [TIME_W-1:0] right_ts,
    input  logic [EV_W-1:0]   right_ev,
    output logic [TIME_W-1:0] ts,
    output logic [EV_W-1:0]   ev,
    output logic              le,
    output logic              expired
);

    logic [TIME_W-1:0] ts_reg, ts_next;
    logic [EV_W-1:0]   ev_reg, ev_next;
    logic [TIME_W-1:0] delay;

    assign delay   = newest - ts_reg;
    assign le      = cell_valid && (ts_reg <= ctrl.new_time);
    // slice above history is the same as delay reaching history*len + len/2
    assign expired = cell_valid && (delay >= {{(TIME_W-THR_W){1'b0}}, thr});

    always_comb
    begin
        ts_next = ts_reg;
        ev_next = ev_reg;
        case (ctrl.op)
            OP_SHIFT:
            begin
                ts_next = right_ts;
                ev_next = right_ev;
            end
            OP_INSERT:
            begin
                if (le)
                begin
                    ts_next = ts_reg;
                    ev_next = ev_reg;
                end
                else if (le_left)
                begin
                    ts_next = ctrl.new_time;
                    ev_next = ctrl.new_ev;
                end
                else
                begin
                    ts_next = left_ts;
                    ev_next = left_ev;
                end
            end
            default:
            begin
                ts_next = ts_reg;
                ev_next = ev_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        ts_reg <= ts_next;
        ev_reg <= ev_next;
    end

    assign ts = ts_reg;
    assign ev = ev_reg;

endmodule

@@ design/towt_row.sv @@
// one node list: a row of entry cells and its fill count
// depends on towt_pkg and towt_cell
module towt_row
    import towt_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int LEN_W = 5
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  row_ctrl_t         ctrl,
    input  logic [TIME_W-1:0] newest,
    input  logic [THR_W-1:0]  thr,
    input  logic [3:0]        rd_slot,
    output logic [LEN_W-1:0]  len,
    output row_stat_t         stat
);

    logic [LEN_W-1:0]  len_reg, len_next;
    logic [TIME_W-1:0] ts      [DEPTH];
    logic [EV_W-1:0]   evs     [DEPTH];
    logic              le      [DEPTH];
    logic              expired [DEPTH];

    for (genvar k = 0; k < DEPTH; k++)
    begin : g_cell
        logic              le_l;
        logic [TIME_W-1:0] l_ts, r_ts;
        logic [EV_W-1:0]   l_ev, r_ev;

        if (k == 0)
        begin : g_first
            assign le_l = 1'b1;
            assign l_ts = '0;
            assign l_ev = '0;
        end
        else
        begin : g_inner
            assign le_l = le[k-1];
            assign l_ts = ts[k-1];
            assign l_ev = evs[k-1];
        end

        if (k == DEPTH - 1)
        begin : g_last
            assign r_ts = ts[k];
            assign r_ev = evs[k];
        end
        else
        begin : g_body
            assign r_ts = ts[k+1];
            assign r_ev = evs[k+1];
        end

        towt_cell u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .newest     (newest),
            .thr        (thr),
            .cell_valid (LEN_W'(k) < len_reg),
            .le_left    (le_l),
            .left_ts    (l_ts),
            .left_ev    (l_ev),
            .right_ts   (r_ts),
            .right_ev   (r_ev),
            .ts         (ts[k]),
            .ev         (evs[k]),
            .le         (le[k]),
            .expired    (expired[k])
        );
    end

    always_comb
    begin
        case (ctrl.op)
            OP_SHIFT:  len_next = len_reg - 1'b1;
            OP_INSERT: len_next = len_reg + 1'b1;
            default:   len_next = len_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            len_reg <= '0;
        else
            len_reg <= len_next;
    end

    always_comb
    begin
        stat.head_exp = expired[0];
        stat.rd_time  = '0;
        stat.rd_ev    = '0;
        for (int k = 0; k < DEPTH; k++)
        begin
            if (int'(rd_slot) == k)
            begin
                stat.rd_time = ts[k];
                stat.rd_ev   = evs[k];
            end
        end
    end

    assign len = len_reg;

endmodule

@@ design/towt_div.sv @@
// rounded slice of a delay, one quotient bit a cycle, saturated at 256
// depends on towt_pkg
module towt_div
    import towt_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [TIME_W-1:0] dividend,
    input  logic [15:0]       divisor,
    output logic              done,
    output logic [8:0]        slice
);

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [2:0]  step_reg, step_next;
    logic [23:0] rem_reg, rem_next;
    logic [7:0]  q_reg, q_next;
    logic        sat_reg, sat_next;
    logic [32:0] biased;
    logic [23:0] sub;

    // adding len - len/2 turns the rounding into a plain floor
    assign biased = {1'b0, dividend} + 33'(divisor - (divisor >> 1));
    assign sub    = {8'b0, divisor} << step_reg;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        sat_next  = sat_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = 3'd7;
            rem_next  = biased[23:0];
            q_next    = '0;
            sat_next  = biased >= {9'b0, divisor, 8'b0};
        end
        else if (busy_reg)
        begin
            if (rem_reg >= sub)
            begin
                rem_next         = rem_reg - sub;
                q_next[step_reg] = 1'b1;
            end
            step_next = step_reg - 1'b1;
            if (step_reg == 3'd0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        step_reg <= step_next;
        rem_reg  <= rem_next;
        q_reg    <= q_next;
        sat_reg  <= sat_next;
    end

    assign done  = done_reg;
    assign slice = sat_reg ? SLICE_SAT : {1'b0, q_reg};

endmodule

@@ design/timed_observation_window_store.sv @@
// top level of the timed observation window store
// depends on towt_pkg, towt_row, towt_div and the assertion macro header
//
// usage
// - input channel in_valid/in_ready takes one request word: an add
//   (req_type 0) or a read (req_type 1) of one node list
// - output channel out_valid/out_ready returns one result word per request
// - cfg_valid/cfg_ready writes slice_length (index 0) or history_slices
//   (index 1) from cfg_data; always ready, write only while idle
// - one request at a time: an add goes through decode, a drop for a full
//   list, the insert and then eviction passes while any list has an expired
//   oldest entry (every expired list drops its oldest entry); a read goes
//   through slot select and the 8 step slice divider; the next request is
//   taken the cycle after the result is loaded
// - every list is a row of cells; inserts and evictions shift entries
//   between neighbouring cells
// - reset empties all lists, clears the newest time and loads the default
//   slice settings; no clearing pass is needed
// - a stalled receiver holds the result in the output register; the next
//   request is taken once that result has been moved there
`include "timed_observation_window_store_assert.svh"

module timed_observation_window_store
    import towt_pkg::*;
#(
    parameter int NODE_COUNT = 8,
    parameter int LIST_DEPTH = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        req_type,
    input  logic [2:0]  node_index,
    input  logic [31:0] arrival_time,
    input  logic [7:0]  evidence_value,
    input  logic [3:0]  read_slot,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        entry_valid,
    output logic [31:0] entry_time,
    output logic [7:0]  entry_evidence,
    output logic [31:0] entry_delay,
    output logic [8:0]  entry_slice,
    output logic [4:0]  list_count,
    output logic        order_violation,
    output logic [7:0]  evicted_count,
    output logic        full_drop,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int LEN_W = $clog2(LIST_DEPTH + 1);

    state_t state_reg, state_next;

    logic              req_reg;
    logic [2:0]        node_reg;
    logic [TIME_W-1:0] t_reg;
    logic [EV_W-1:0]   ev_reg;
    logic [3:0]        slot_reg;

    logic              viol_reg, full_reg, rd_valid_reg;
    logic [7:0]        evict_reg;
    logic [TIME_W-1:0] rd_time_reg, rd_delay_reg;
    logic [EV_W-1:0]   rd_ev_reg;

    logic [TIME_W-1:0] newest_reg;
    logic [15:0]       slice_len_reg;
    logic [7:0]        hist_reg;
    logic [THR_W-1:0]  thr_reg;
    logic [15:0]       s_eff;

    logic              out_valid_reg;
    logic              res_valid_reg, res_viol_reg, res_full_reg;
    logic [TIME_W-1:0] res_time_reg, res_delay_reg;
    logic [EV_W-1:0]   res_ev_reg;
    logic [8:0]        res_slice_reg;
    logic [4:0]        res_count_reg;
    logic [7:0]        res_evict_reg;

    row_ctrl_t         ctrl [NODE_COUNT];
    row_stat_t         stat [NODE_COUNT];
    logic [LEN_W-1:0]  lens [NODE_COUNT];

    logic              node_ok;
    logic [LEN_W-1:0]  len_sel;
    row_stat_t         stat_sel;
    logic              any_exp;
    logic [7:0]        shift_cnt;
    logic [8:0]        evict_sum;
    logic              div_start, div_done;
    logic [8:0]        div_slice;
    logic              load_out;
    logic [TIME_W-1:0] rd_delay;

    assign node_ok = int'(node_reg) < NODE_COUNT;
    assign s_eff   = (slice_len_reg == 16'd0) ? 16'd1 : slice_len_reg;

    always_comb
    begin
        len_sel   = '0;
        stat_sel  = '0;
        any_exp   = 1'b0;
        shift_cnt = '0;
        for (int n = 0; n < NODE_COUNT; n++)
        begin
            if (int'(node_reg) == n)
            begin
                len_sel  = lens[n];
                stat_sel = stat[n];
            end
            any_exp   = any_exp | stat[n].head_exp;
            shift_cnt = shift_cnt + 8'(stat[n].head_exp);
        end
    end

    assign evict_sum = {1'b0, evict_reg} + {1'b0, shift_cnt};
    assign rd_delay  = newest_reg - stat_sel.rd_time;
    assign load_out  = (state_reg == S_DONE) && (!out_valid_reg || out_ready);

    for (genvar n = 0; n < NODE_COUNT; n++)
    begin : g_row
        towt_row #(
            .DEPTH (LIST_DEPTH),
            .LEN_W (LEN_W)
        ) u_row (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctrl    (ctrl[n]),
            .newest  (newest_reg),
            .thr     (thr_reg),
            .rd_slot (slot_reg),
            .len     (lens[n]),
            .stat    (stat[n])
        );
    end

    towt_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (rd_delay),
        .divisor  (s_eff),
        .done     (div_done),
        .slice    (div_slice)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
                if (in_valid)
                    state_next = S_DECODE;
            S_DECODE:
                if (!node_ok)
                    state_next = S_DONE;
                else if (req_reg == REQ_READ)
                    state_next = S_RSEL;
                else if (int'(len_sel) >= LIST_DEPTH)
                    state_next = S_DROP;
                else
                    state_next = S_INSERT;
            S_DROP:   state_next = S_INSERT;
            S_INSERT: state_next = S_EVICT;
            S_EVICT:
                if (!any_exp)
                    state_next = S_DONE;
            S_RSEL:   state_next = S_RDIV;
            S_RDIV:
                if (div_done)
                    state_next = S_DONE;
            S_DONE:
                if (load_out)
                    state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        in_ready  = 1'b0;
        div_start = 1'b0;
        for (int n = 0; n < NODE_COUNT; n++)
        begin
            ctrl[n].op       = OP_HOLD;
            ctrl[n].new_time = t_reg;
            ctrl[n].new_ev   = ev_reg;
        end
        case (state_reg)
            S_IDLE: in_ready = 1'b1;
            S_DROP:
                for (int n = 0; n < NODE_COUNT; n++)
                    if (int'(node_reg) == n)
                        ctrl[n].op = OP_SHIFT;
            S_INSERT:
                for (int n = 0; n < NODE_COUNT; n++)
                    if (int'(node_reg) == n)
                        ctrl[n].op = OP_INSERT;
            S_EVICT:
                for (int n = 0; n < NODE_COUNT; n++)
                    if (stat[n].head_exp)
                        ctrl[n].op = OP_SHIFT;
            S_RSEL: div_start = 1'b1;
            default:
            begin
                in_ready  = 1'b0;
                div_start = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            newest_reg    <= '0;
            slice_len_reg <= SLICE_LENGTH_RST;
            hist_reg      <= HISTORY_SLICES_RST;
            out_valid_reg <= 1'b0;
            viol_reg      <= 1'b0;
            full_reg      <= 1'b0;
            evict_reg     <= '0;
            rd_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_SLICE_LENGTH)
                    slice_len_reg <= cfg_data;
                else if (cfg_index == CFG_HISTORY_SLICES)
                    hist_reg <= cfg_data[7:0];
            end
            if (in_valid && in_ready)
            begin
                viol_reg     <= 1'b0;
                full_reg     <= 1'b0;
                evict_reg    <= '0;
                rd_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_DROP: full_reg <= 1'b1;
                S_INSERT:
                begin
                    viol_reg <= t_reg < newest_reg;
                    if (t_reg >= newest_reg)
                        newest_reg <= t_reg;
                end
                S_EVICT:
                    evict_reg <= evict_sum[8] ? 8'hFF : evict_sum[7:0];
                S_RSEL:
                    rd_valid_reg <= int'(slot_reg) < int'(len_sel);
                default:
                begin
                end
            endcase
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        // threshold in ms: history*len + len/2
        thr_reg <= THR_W'(hist_reg * s_eff) + THR_W'(s_eff >> 1);
        if (in_valid && in_ready)
        begin
            req_reg  <= req_type;
            node_reg <= node_index;
            t_reg    <= arrival_time;
            ev_reg   <= evidence_value;
            slot_reg <= read_slot;
        end
        if (state_reg == S_RSEL)
        begin
            rd_time_reg  <= stat_sel.rd_time;
            rd_ev_reg    <= stat_sel.rd_ev;
            rd_delay_reg <= rd_delay;
        end
        if (load_out)
        begin
            res_valid_reg <= rd_valid_reg;
            res_time_reg  <= rd_valid_reg ? rd_time_reg : '0;
            res_ev_reg    <= rd_valid_reg ? rd_ev_reg : '0;
            res_delay_reg <= rd_valid_reg ? rd_delay_reg : '0;
            res_slice_reg <= rd_valid_reg ? div_slice : '0;
            res_count_reg <= node_ok ? 5'(len_sel) : '0;
            res_viol_reg  <= viol_reg;
            res_evict_reg <= evict_reg;
            res_full_reg  <= full_reg;
        end
    end

    assign cfg_ready       = 1'b1;
    assign out_valid       = out_valid_reg;
    assign entry_valid     = res_valid_reg;
    assign entry_time      = res_time_reg;
    assign entry_evidence  = res_ev_reg;
    assign entry_delay     = res_delay_reg;
    assign entry_slice     = res_slice_reg;
    assign list_count      = res_count_reg;
    assign order_violation = res_viol_reg;
    assign evicted_count   = res_evict_reg;
    assign full_drop       = res_full_reg;

    `TOWT_ASSERT_NXT(a_accept_decodes, in_valid && in_ready, state_reg == S_DECODE,
        "accepted word did not reach decode")
    `TOWT_ASSERT_NXT(a_drop_then_insert, state_reg == S_DROP,
        state_reg == S_INSERT && full_reg, "drop not followed by insert")
    `TOWT_ASSERT_NXT(a_evict_monotonic, state_reg == S_EVICT,
        evict_reg >= $past(evict_reg), "eviction count went down")
    `TOWT_ASSERT_NXT(a_done_holds, state_reg == S_DONE && out_valid_reg && !out_ready,
        state_reg == S_DONE, "result overwritten while output stalled")

endmodule
